FILE: rtl/ftsd_pkg.sv
// ----------------------------------------------------------------------------
// ftsd_pkg: shared types, constants and membership helpers
// Q0.16 fuzzy drive controller: distance breakpoints, ramp tables, codes.
// ----------------------------------------------------------------------------
package ftsd_pkg;

    localparam int DistFracBits = 4;
    localparam int DistW        = 16;
    localparam int QW           = 17;          // Q0.16 with 1.0 representable
    localparam logic [QW-1:0] QOne = 17'h10000;
    localparam int LevelW       = 8;
    localparam int Rules        = 7;
    localparam int RuleIdxW     = 3;
    localparam int NumW         = 28;          // 7 * 2^16 * 128 fits in signed 28
    localparam int SumW         = 20;          // 7 * 2^16
    localparam int QuotW        = 9;           // |quotient| <= 128

    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CfgReverse   = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgCurveNear = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgCurveMid  = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgFast      = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgMax       = 3'd4;

    localparam int Cm = 1 << DistFracBits;
    localparam logic [DistW:0] Cm999 = (DistW+1)'(999 * Cm);

    // ceil(2^22 / 5): exact floor(x / 5) for x below 2^22
    localparam int Recip5 = 838861;

    typedef struct packed {
        logic [DistW-1:0] left_distance;
        logic [DistW-1:0] middle_distance;
        logic [DistW-1:0] right_distance;
    } sensor_word_t;

    typedef struct packed {
        logic signed [LevelW-1:0] left_speed;
        logic signed [LevelW-1:0] right_speed;
        logic                     searching;
    } drive_word_t;

    typedef struct packed {
        logic signed [LevelW-1:0] reverse_level;
        logic signed [LevelW-1:0] curve_near_level;
        logic signed [LevelW-1:0] curve_mid_level;
        logic signed [LevelW-1:0] fast_level;
        logic signed [LevelW-1:0] max_level;
    } cfg_t;

    typedef struct packed {
        logic [QW-1:0] n;
        logic [QW-1:0] m;
        logic [QW-1:0] f;
    } memb_t;

    typedef logic signed [DistW+1:0] sdist_t;

    // span * 65536 / (10 cm) = span * 2048 / 5, by reciprocal multiplication
    function automatic logic [QW-1:0] ramp10(input logic [DistW:0] span);
        logic [DistW+20:0] p;
        begin
            p = (DistW+21)'(span) * (DistW+21)'(Recip5);
            return p[QW+10:11];
        end
    endfunction

    // span * 65536 / (20 cm) = span * 1024 / 5
    function automatic logic [QW-1:0] ramp20(input logic [DistW+1:0] span);
        logic [DistW+21:0] p;
        begin
            p = (DistW+22)'(span) * (DistW+22)'(Recip5);
            return p[QW+11:12];
        end
    endfunction

    function automatic logic [DistW:0] clean(input logic [DistW-1:0] raw);
        logic [DistW+4:0] t;
        begin
            t = (DistW+5)'(raw) * (DistW+5)'(10);
            if (t <= (DistW+5)'(Cm)) return Cm999;
            return {1'b0, raw};
        end
    endfunction

    function automatic memb_t member(input logic [DistW:0] x);
        memb_t r;
        begin
            if (x <= (DistW+1)'(15*Cm))      r.n = QOne;
            else if (x >= (DistW+1)'(25*Cm)) r.n = '0;
            else r.n = ramp10((DistW+1)'(25*Cm) - x);
            if (x <= (DistW+1)'(20*Cm) || x >= (DistW+1)'(55*Cm)) r.m = '0;
            else if (x <= (DistW+1)'(30*Cm)) r.m = ramp10(x - (DistW+1)'(20*Cm));
            else if (x <= (DistW+1)'(45*Cm)) r.m = QOne;
            else r.m = ramp10((DistW+1)'(55*Cm) - x);
            if (x <= (DistW+1)'(50*Cm))      r.f = '0;
            else if (x >= (DistW+1)'(60*Cm)) r.f = QOne;
            else r.f = ramp10(x - (DistW+1)'(50*Cm));
            return r;
        end
    endfunction

    // degree to which p is less than q
    function automatic logic [QW-1:0] soft_less(input logic [DistW:0] p,
                                                 input logic [DistW:0] q);
        sdist_t d;
        begin
            d = sdist_t'({1'b0, q}) - sdist_t'({1'b0, p});
            if (d >= sdist_t'(10*Cm))  return QOne;
            if (d <= -sdist_t'(10*Cm)) return '0;
            return ramp20((DistW+2)'(d + sdist_t'(10*Cm)));
        end
    endfunction

    function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a,
                                           input logic [QW-1:0] b);
        logic [2*QW-1:0] p;
        begin
            p = a * b;
            return p[QW+15:16];
        end
    endfunction

    function automatic logic signed [LevelW-1:0] clamp100(
        input logic signed [QuotW:0] v);
        begin
            if (v > 100)  return LevelW'(100);
            if (v < -100) return -LevelW'(100);
            return v[LevelW-1:0];
        end
    endfunction

endpackage

FILE: rtl/ftsd_stream_if.sv
// ----------------------------------------------------------------------------
// ftsd_stream_if: valid/ready channel
// Carries one word of the given payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface ftsd_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ftsd_rule_lane.sv
// ----------------------------------------------------------------------------
// ftsd_rule_lane: one steering rule weight
// Chains up to four Q0.16 products, one product per stage.
// ----------------------------------------------------------------------------
module ftsd_rule_lane
(
    input  logic                 clk,
    input  logic                 adv,
    input  logic [ftsd_pkg::QW-1:0] f0,
    input  logic [ftsd_pkg::QW-1:0] f1,
    input  logic [ftsd_pkg::QW-1:0] f2,
    input  logic [ftsd_pkg::QW-1:0] f3,
    input  logic [ftsd_pkg::QW-1:0] f4,
    output logic [ftsd_pkg::QW-1:0] weight
);
    import ftsd_pkg::*;

    logic [QW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [QW-1:0] a2_reg, a3_reg, a4_reg, b3_reg, b4_reg, c4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= qmul(f0, f1);
            a2_reg <= f2; b3_reg <= f3; c4_reg <= f4;
            p2_reg <= qmul(p1_reg, a2_reg);
            a3_reg <= b3_reg; b4_reg <= c4_reg;
            p3_reg <= qmul(p2_reg, a3_reg);
            a4_reg <= b4_reg;
            p4_reg <= qmul(p3_reg, a4_reg);
        end
    end

    assign weight = p4_reg;
endmodule

FILE: rtl/ftsd_divider.sv
// ----------------------------------------------------------------------------
// ftsd_divider: pipelined signed quotient of weighted sum by weight sum
// Restoring division, one quotient bit per stage, truncation toward zero.
// ----------------------------------------------------------------------------
module ftsd_divider
(
    input  logic                          clk,
    input  logic                          adv,
    input  logic signed [ftsd_pkg::NumW-1:0] num,
    input  logic [ftsd_pkg::SumW-1:0]     den,
    output logic signed [ftsd_pkg::QuotW:0]  quot
);
    import ftsd_pkg::*;

    localparam int RemW = SumW + 1;

    logic [QuotW-1:0] q_reg   [QuotW+1];
    logic [RemW-1:0]  rem_reg [QuotW+1];
    logic [NumW-1:0]  mag_reg [QuotW+1];
    logic [SumW-1:0]  den_reg [QuotW+1];
    logic             neg_reg [QuotW+1];
    logic [NumW-1:0]  mag_in;

    assign mag_in = num[NumW-1] ? NumW'(-num) : NumW'(num);

    // quotient magnitude below 2^QuotW, so only the low QuotW bits are developed;
    // the upper numerator bits form the starting remainder
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg[0] <= mag_in;
            neg_reg[0] <= num[NumW-1];
            den_reg[0] <= den;
            rem_reg[0] <= RemW'(mag_in >> QuotW);
            q_reg[0]   <= '0;
        end
    end

    for (genvar s = 0; s < QuotW; s++)
    begin : g_stage
        logic [RemW:0]        trial;
        logic [RemW-1:0]      cur;
        assign cur   = rem_reg[s];
        assign trial = {cur, mag_reg[s][QuotW-1-s]} - {2'b0, den_reg[s]};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mag_reg[s+1] <= mag_reg[s];
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                if (!trial[RemW])
                begin
                    rem_reg[s+1] <= trial[RemW-1:0];
                    q_reg[s+1]   <= {q_reg[s][QuotW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= {cur[RemW-2:0], mag_reg[s][QuotW-1-s]};
                    q_reg[s+1]   <= {q_reg[s][QuotW-2:0], 1'b0};
                end
            end
        end
    end

    assign quot = neg_reg[QuotW] ? -$signed({1'b0, q_reg[QuotW]})
                                 : $signed({1'b0, q_reg[QuotW]});
endmodule

FILE: rtl/fuzzy_three_sensor_drive_unit.sv
// ----------------------------------------------------------------------------
// fuzzy_three_sensor_drive_unit: three-sensor fuzzy wheel speed controller
// Seven rules weight the memberships, a merge stage sums them and a
// pipelined divider forms the weighted average of the rule speed levels.
//
//   channel  dir  payload
//   sensor   in   left/middle/right distance, 16 b each
//   drive    out  left/right speed 8 b signed, searching 1 b
//   cfg      in   wr_en, wr_index 3 b, wr_data 8 b
//
// One word per cycle unless the output word waits; the pipeline stages are
// memberships, four product stages, far rule product, level products, sum,
// divider input register, nine divider stages, output register.
// Reset clears the pipeline valid bits and loads the default levels.
// The whole pipeline holds while the output word waits.
// ----------------------------------------------------------------------------
module fuzzy_three_sensor_drive_unit
(
    input  logic clk,
    input  logic rst_n,
    ftsd_stream_if.sink   sensor,
    ftsd_stream_if.source drive,
    input  logic                          wr_en,
    input  logic [ftsd_pkg::CfgIdxW-1:0]  wr_index,
    input  logic [ftsd_pkg::LevelW-1:0]   wr_data
);
    import ftsd_pkg::*;

    localparam int Depth = 19;

    cfg_t cfg_reg;
    logic [Depth-1:0] vld_reg;
    logic adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reverse_level    <= -LevelW'(85);
            cfg_reg.curve_near_level <= LevelW'(60);
            cfg_reg.curve_mid_level  <= LevelW'(70);
            cfg_reg.fast_level       <= LevelW'(90);
            cfg_reg.max_level        <= LevelW'(100);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CfgReverse:   cfg_reg.reverse_level    <= wr_data;
                CfgCurveNear: cfg_reg.curve_near_level <= wr_data;
                CfgCurveMid:  cfg_reg.curve_mid_level  <= wr_data;
                CfgFast:      cfg_reg.fast_level       <= wr_data;
                CfgMax:       cfg_reg.max_level        <= wr_data;
                default:      ;
            endcase
        end
    end

    assign adv = !drive.valid || drive.ready;
    assign sensor.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Depth-2:0], sensor.valid};
    end
    assign drive.valid = vld_reg[Depth-1];

    // stage 1: clean readings, memberships, soft ramps
    memb_t ml_reg, mm_reg, mr_reg;
    logic [QW-1:0] s_ml_reg, s_mr_reg, s_lm_reg, s_lr_reg, s_rl_reg, s_rm_reg;
    logic [DistW:0] cl, cm, cr;

    assign cl = clean(sensor.data.left_distance);
    assign cm = clean(sensor.data.middle_distance);
    assign cr = clean(sensor.data.right_distance);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ml_reg <= member(cl);
            mm_reg <= member(cm);
            mr_reg <= member(cr);
            s_ml_reg <= soft_less(cm, cl);
            s_mr_reg <= soft_less(cm, cr);
            s_lm_reg <= soft_less(cl, cm);
            s_lr_reg <= soft_less(cl, cr);
            s_rl_reg <= soft_less(cr, cl);
            s_rm_reg <= soft_less(cr, cm);
        end
    end

    // lanes
    logic [QW-1:0] w [Rules];
    logic [QW-1:0] d0_reg [4], d1_reg [4], d2_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_reg[0] <= mm_reg.n; d1_reg[0] <= ml_reg.n; d2_reg[0] <= mr_reg.n;
            for (int k = 1; k < 4; k++)
            begin
                d0_reg[k] <= d0_reg[k-1];
                d1_reg[k] <= d1_reg[k-1];
                d2_reg[k] <= d2_reg[k-1];
            end
        end
    end
    assign w[0] = d0_reg[3];
    assign w[1] = d1_reg[3];
    assign w[2] = d2_reg[3];

    ftsd_rule_lane u_lane3 (.clk(clk), .adv(adv), .f0(mm_reg.m),
        .f1(QOne - ml_reg.n), .f2(QOne - mr_reg.n), .f3(s_ml_reg), .f4(s_mr_reg),
        .weight(w[3]));
    ftsd_rule_lane u_lane4 (.clk(clk), .adv(adv), .f0(ml_reg.m),
        .f1(QOne - mm_reg.n), .f2(QOne - mr_reg.n), .f3(s_lm_reg), .f4(s_lr_reg),
        .weight(w[4]));
    ftsd_rule_lane u_lane5 (.clk(clk), .adv(adv), .f0(mr_reg.m),
        .f1(QOne - ml_reg.n), .f2(QOne - mm_reg.n), .f3(s_rl_reg), .f4(s_rm_reg),
        .weight(w[5]));
    ftsd_rule_lane u_lane6 (.clk(clk), .adv(adv), .f0(ml_reg.f),
        .f1(mm_reg.f), .f2(QOne), .f3(QOne), .f4(QOne), .weight(w[6]));

    // merge: per-rule products, then sums
    logic signed [LevelW-1:0] lv [Rules], rv [Rules];
    always_comb
    begin
        lv[0] = cfg_reg.max_level;        rv[0] = cfg_reg.max_level;
        lv[1] = cfg_reg.curve_near_level; rv[1] = cfg_reg.max_level;
        lv[2] = cfg_reg.max_level;        rv[2] = cfg_reg.curve_near_level;
        lv[3] = cfg_reg.fast_level;       rv[3] = cfg_reg.fast_level;
        lv[4] = cfg_reg.curve_mid_level;  rv[4] = cfg_reg.fast_level;
        lv[5] = cfg_reg.fast_level;       rv[5] = cfg_reg.curve_mid_level;
        lv[6] = cfg_reg.fast_level;       rv[6] = cfg_reg.reverse_level;
    end

    logic [QW-1:0] fr_d_reg [4];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fr_d_reg[0] <= mr_reg.f;
            for (int k = 1; k < 4; k++)
                fr_d_reg[k] <= fr_d_reg[k-1];
        end
    end
    // far rule needs its third factor; take it with one product here
    logic signed [QW+LevelW:0] lp_reg [Rules], rp_reg [Rules];
    logic [QW-1:0] wq_reg [Rules];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < Rules; k++)
                wq_reg[k] <= (k == 6) ? qmul(w[6], fr_d_reg[3]) : w[k];
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < Rules; k++)
            begin
                lp_reg[k] <= $signed({1'b0, wq_reg[k]}) * lv[k];
                rp_reg[k] <= $signed({1'b0, wq_reg[k]}) * rv[k];
            end
        end
    end
    logic [SumW-1:0] ws_reg;
    logic signed [NumW-1:0] ln_reg, rn_reg;
    logic signed [NumW-1:0] ln_c, rn_c;
    always_comb
    begin
        ln_c = '0; rn_c = '0;
        for (int k = 0; k < Rules; k++)
        begin
            ln_c = ln_c + NumW'(lp_reg[k]);
            rn_c = rn_c + NumW'(rp_reg[k]);
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ln_reg <= ln_c;
            rn_reg <= rn_c;
        end
    end
    // weight sum for the same word, aligned with the products stage
    logic [SumW-1:0] wsp_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wsp_reg <= SumW'(wq_reg[0]) + SumW'(wq_reg[1]) + SumW'(wq_reg[2])
                     + SumW'(wq_reg[3]) + SumW'(wq_reg[4]) + SumW'(wq_reg[5])
                     + SumW'(wq_reg[6]);
            ws_reg <= wsp_reg;
        end
    end

    logic signed [QuotW:0] lq, rq;
    logic [SumW-1:0] den;
    assign den = (ws_reg == '0) ? SumW'(1) : ws_reg;

    ftsd_divider u_div_l (.clk(clk), .adv(adv), .num(ln_reg), .den(den), .quot(lq));
    ftsd_divider u_div_r (.clk(clk), .adv(adv), .num(rn_reg), .den(den), .quot(rq));

    logic zero_d_reg [QuotW+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_d_reg[0] <= (ws_reg == '0);
            for (int k = 1; k <= QuotW; k++)
                zero_d_reg[k] <= zero_d_reg[k-1];
        end
    end

    logic signed [LevelW-1:0] ls_reg, rs_reg;
    logic srch_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            srch_reg <= zero_d_reg[QuotW];
            if (zero_d_reg[QuotW])
            begin
                ls_reg <= clamp100((QuotW+1)'(cfg_reg.fast_level));
                rs_reg <= clamp100(-(QuotW+1)'(cfg_reg.fast_level));
            end
            else
            begin
                ls_reg <= clamp100(lq);
                rs_reg <= clamp100(rq);
            end
        end
    end

    assign drive.data.left_speed  = ls_reg;
    assign drive.data.right_speed = rs_reg;
    assign drive.data.searching   = srch_reg;
endmodule
